// File: rtl/core/rbpa_pkg.sv
// Shared types and constants of the region bitmap page allocator.
`timescale 1ns / 1ps

package rbpa_pkg;

  // Fixed field widths.
  localparam int AddrW    = 48;
  localparam int PagesW   = 13;
  localparam int FuncW    = 2;

  // Bitmap words hold 64 pages each.
  localparam int WordBits = 64;
  localparam int WordSelW = 6;

  // Page counts are rounded down to a multiple of this group size.
  localparam int PageGroup = 8;

  // The register file always holds four areas.
  localparam int RegAreas = 4;
  localparam int AreaIdxW = 2;

  // Register port geometry: eight 64-bit registers at 8-byte spacing.
  localparam int CfgAw = 6;
  localparam int CfgDw = 64;
  localparam int RegIdxW = 3;
  localparam logic [RegIdxW-1:0] RegFirstPages = 3'd4;

  // Request kinds.
  localparam logic [FuncW-1:0] FuncFind  = 2'd0;
  localparam logic [FuncW-1:0] FuncClaim = 2'd1;
  localparam logic [FuncW-1:0] FuncFree  = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [AddrW-1:0] page_address;
  } in_beat_t;

  typedef struct packed {
    logic             hit;
    logic [AddrW-1:0] result_address;
  } out_beat_t;

  typedef struct packed {
    logic [AddrW-1:0]  base;
    logic [PagesW-1:0] pages;
  } area_cfg_t;

  // Operands of the shared address adder.
  typedef struct packed {
    logic [AddrW-1:0] op_a;
    logic [AddrW-1:0] op_b;
    logic             sub;
  } addr_op_t;

endpackage

// File: rtl/core/rbpa_cfg_regs.sv
// Register file of area bases and page counts behind the APB-style port.
`timescale 1ns / 1ps

module rbpa_cfg_regs
  import rbpa_pkg::*;
(
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [CfgAw-1:0]                    paddr,
  input  logic [CfgDw-1:0]                    pwdata,
  output logic [CfgDw-1:0]                    prdata,
  output logic                                pready,
  output area_cfg_t [RegAreas-1:0]            area_cfg_o
);

  area_cfg_t [RegAreas-1:0] cfg_q;
  logic [RegIdxW-1:0]       reg_idx;
  logic [AreaIdxW-1:0]      area_sel;
  logic                     wr_en;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[CfgAw-1:CfgAw-RegIdxW];
  assign area_sel = reg_idx[AreaIdxW-1:0];
  assign wr_en    = psel & penable & pwrite & pready;

  // Registers are written in the access phase of a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      if (reg_idx < RegFirstPages) begin
        cfg_q[area_sel].base <= pwdata[AddrW-1:0];
      end else begin
        cfg_q[area_sel].pages <= pwdata[PagesW-1:0];
      end
    end
  end

  // Read data is the selected register, zero-extended.
  always_comb begin
    if (reg_idx < RegFirstPages) begin
      prdata = CfgDw'(cfg_q[area_sel].base);
    end else begin
      prdata = CfgDw'(cfg_q[area_sel].pages);
    end
  end

  assign area_cfg_o = cfg_q;

endmodule

// File: rtl/core/rbpa_addr_unit.sv
// Shared 48-bit add/subtract unit used for range checks and page addresses.
`timescale 1ns / 1ps

module rbpa_addr_unit
  import rbpa_pkg::*;
(
  input  addr_op_t         op_i,
  output logic [AddrW:0]   sum_o
);

  logic [AddrW:0] b_ext;

  // Subtraction is a plus the inverted b plus one; bit 48 then flags a borrow.
  assign b_ext = op_i.sub ? ~{1'b0, op_i.op_b} : {1'b0, op_i.op_b};
  assign sum_o = {1'b0, op_i.op_a} + b_ext + (AddrW + 1)'(op_i.sub);

endmodule

// File: rtl/core/rbpa_bitmap.sv
// Used-page bitmap memory with a clearing sweep after reset.
`timescale 1ns / 1ps

module rbpa_bitmap
  import rbpa_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic [WordBits-1:0] wr_data_i,
  output logic [WordBits-1:0] rd_data_o,
  output logic                clr_busy_o
);

  logic [WordBits-1:0] mem [DEPTH];
  logic [WordBits-1:0] rd_data_q;
  logic [AW-1:0]       clr_idx_q;
  logic                clr_busy_q;

  // Clearing sweep: one word per cycle from address zero upward.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + AW'(1);
      end
    end
  end

  // Single write port, shared between the sweep and the sequencer.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

// File: rtl/core/region_bitmap_page_allocator_unit.sv
// Top level of the region bitmap page allocator: request sequencer and glue.
//
// Usage: requests arrive as beats on the input channel (in_valid_i, in_stall_o,
// in_data_i) and each one yields exactly one beat on the output channel
// (out_valid_o, out_stall_i, out_data_o). The user must set area bases and page
// counts through the APB-style register port only while no request is in
// flight; the block itself does not enforce this.
// A find request scans the used bitmap one 64-page word per cycle, area by
// area, with 256 word reads at most with the default sizes. A claim or free
// request works through every area in turn, subtracting the base and checking
// the range, and reads and rewrites the bitmap word in each area that holds
// the address. The sequencer uses the single bitmap memory port and the shared
// address adder; one request is worked on at a time.
// After reset the bitmap is swept to all free, one word per cycle; in_stall_o
// stays high meanwhile while register writes are taken as usual.
// A finished result sits in an output register; if the receiver stalls,
// the block holds it there, may still take and work on the next request,
// and then waits with that next result until the output register frees.
`timescale 1ns / 1ps

module region_bitmap_page_allocator_unit
  import rbpa_pkg::*;
#(
  parameter int AREA_COUNT     = 4,
  parameter int PAGES_PER_AREA = 4096,
  parameter int PAGE_SHIFT     = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_beat_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_beat_t        out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [CfgAw-1:0] paddr,
  input  logic [CfgDw-1:0] pwdata,
  output logic [CfgDw-1:0] prdata,
  output logic             pready
);

  localparam int WordsPerArea = (PAGES_PER_AREA + WordBits - 1) / WordBits;
  localparam int MemDepth     = AREA_COUNT * WordsPerArea;
  localparam int MemAw        = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int WordW        = (WordsPerArea > 1) ? $clog2(WordsPerArea) : 1;
  localparam int PageIdxW     = WordW + WordSelW;
  localparam int CmpW         = ((PageIdxW > PagesW) ? PageIdxW : PagesW) + 1;
  localparam int OffW         = AddrW - PAGE_SHIFT;
  localparam logic [AreaIdxW-1:0] LastArea = AreaIdxW'(AREA_COUNT - 1);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StFArea = 9'b000000010,
    StFChk  = 9'b000000100,
    StFAddr = 9'b000001000,
    StCSub  = 9'b000010000,
    StCCmp  = 9'b000100000,
    StCRd   = 9'b001000000,
    StCWr   = 9'b010000000,
    StFin   = 9'b100000000
  } state_e;

  // Page count cap and rounding down to a multiple of the group size.
  function automatic logic [PagesW-1:0] eff_pages(logic [PagesW-1:0] p);
    logic [PagesW-1:0] n;
    if (CmpW'(p) > CmpW'(PAGES_PER_AREA)) begin
      n = PagesW'(PAGES_PER_AREA);
    end else begin
      n = p;
    end
    return n & ~PagesW'(PageGroup - 1);
  endfunction

  // Base aligned down to a page.
  function automatic logic [AddrW-1:0] eff_base(logic [AddrW-1:0] b);
    return b & ~AddrW'((64'd1 << PAGE_SHIFT) - 64'd1);
  endfunction

  area_cfg_t [RegAreas-1:0] area_cfg;

  state_e                state_q, state_d;
  logic [AreaIdxW-1:0]   area_q, area_d;
  logic [WordW-1:0]      word_q, word_d;
  logic [WordSelW-1:0]   bit_q, bit_d;
  logic [PageIdxW-1:0]   idx_q, idx_d;
  logic [AddrW:0]        diff_q, diff_d;
  in_beat_t              req_q, req_d;
  logic                  hit_q, hit_d;
  logic [AddrW-1:0]      res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  out_beat_t             out_q, out_d;

  logic                  clr_busy;
  logic                  in_accept;
  logic                  out_free;
  logic                  last_area;
  logic [PagesW-1:0]     area_n;
  logic [AddrW-1:0]      area_base;

  logic                  seq_rd_en;
  logic [WordW-1:0]      rd_word;
  logic [MemAw-1:0]      rd_addr;
  logic                  seq_wr_en;
  logic [MemAw-1:0]      wr_addr;
  logic [WordBits-1:0]   wr_data;
  logic [WordBits-1:0]   rd_data;

  addr_op_t              add_op;
  logic [AddrW:0]        add_sum;

  logic [CmpW-1:0]       word_start;
  logic [CmpW-1:0]       rem;
  logic                  last_word;
  logic [WordBits-1:0]   mask;
  logic [WordBits-1:0]   free_bits;
  logic [WordBits-1:0]   iso;
  logic [WordSelW-1:0]   enc;
  logic                  any_free;
  logic [OffW-1:0]       page_off;
  logic                  in_range;

  rbpa_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .area_cfg_o (area_cfg)
  );

  rbpa_addr_unit u_addr (
    .op_i  (add_op),
    .sum_o (add_sum)
  );

  rbpa_bitmap #(
    .DEPTH (MemDepth),
    .AW    (MemAw)
  ) u_bitmap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (seq_rd_en),
    .rd_addr_i  (rd_addr),
    .wr_en_i    (seq_wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_data_o  (rd_data),
    .clr_busy_o (clr_busy)
  );

  // Handshake terms.
  assign in_stall_o  = (state_q != StIdle) | clr_busy;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration of the area under work.
  assign area_n    = eff_pages(area_cfg[area_q].pages);
  assign area_base = eff_base(area_cfg[area_q].base);
  assign last_area = (area_q == LastArea);

  // Word scan: mask off pages past the area end, then pick the lowest free bit.
  assign word_start = CmpW'({word_q, WordSelW'(0)});
  assign rem        = CmpW'(area_n) - word_start;
  assign last_word  = (word_start + CmpW'(WordBits)) >= CmpW'(area_n);

  always_comb begin
    for (int j = 0; j < WordBits; j++) begin
      mask[j] = CmpW'(j) < rem;
    end
  end

  assign free_bits = ~rd_data & mask;
  assign iso       = free_bits & (~free_bits + WordBits'(1));
  assign any_free  = |free_bits;

  always_comb begin
    enc = '0;
    for (int k = 0; k < WordSelW; k++) begin
      for (int j = 0; j < WordBits; j++) begin
        if (((j >> k) & 1) == 1) begin
          enc[k] = enc[k] | iso[j];
        end
      end
    end
  end

  // Range check on the registered difference of address and base.
  assign page_off = diff_q[AddrW-1:PAGE_SHIFT];
  assign in_range = ~diff_q[AddrW] & (page_off < OffW'(area_n));

  // Shared adder: page address for find, address minus base for claim/free.
  always_comb begin
    if (state_q == StFAddr) begin
      add_op.op_a = area_base;
      add_op.op_b = AddrW'({word_q, bit_q}) << PAGE_SHIFT;
      add_op.sub  = 1'b0;
    end else begin
      add_op.op_a = req_q.page_address;
      add_op.op_b = area_base;
      add_op.sub  = 1'b1;
    end
  end

  // Bitmap addressing: the read runs one word ahead during a scan.
  always_comb begin
    if (state_q == StFChk) begin
      rd_word = word_q + WordW'(1);
    end else if (state_q == StFArea) begin
      rd_word = '0;
    end else begin
      rd_word = idx_q[PageIdxW-1:WordSelW];
    end
  end

  assign rd_addr = MemAw'(int'(area_q) * WordsPerArea + int'(rd_word));
  assign wr_addr = MemAw'(int'(area_q) * WordsPerArea + int'(idx_q[PageIdxW-1:WordSelW]));

  always_comb begin
    wr_data = rd_data;
    wr_data[idx_q[WordSelW-1:0]] = (req_q.func == FuncClaim);
  end

  // Request sequencer.
  always_comb begin
    state_d     = state_q;
    area_d      = area_q;
    word_d      = word_q;
    bit_d       = bit_q;
    idx_d       = idx_q;
    diff_d      = diff_q;
    req_d       = req_q;
    hit_d       = hit_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    seq_rd_en   = 1'b0;
    seq_wr_en   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          req_d  = in_data_i;
          hit_d  = 1'b0;
          res_d  = in_data_i.page_address;
          area_d = '0;
          if (in_data_i.func == FuncFind) begin
            state_d = StFArea;
          end else if (in_data_i.func == FuncClaim || in_data_i.func == FuncFree) begin
            state_d = StCSub;
          end else begin
            state_d = StFin;
          end
        end
      end
      StFArea: begin
        if (area_n == '0) begin
          if (last_area) begin
            res_d   = '0;
            state_d = StFin;
          end else begin
            area_d = area_q + AreaIdxW'(1);
          end
        end else begin
          word_d    = '0;
          seq_rd_en = 1'b1;
          state_d   = StFChk;
        end
      end
      StFChk: begin
        if (any_free) begin
          bit_d   = enc;
          state_d = StFAddr;
        end else if (last_word) begin
          if (last_area) begin
            res_d   = '0;
            state_d = StFin;
          end else begin
            area_d  = area_q + AreaIdxW'(1);
            state_d = StFArea;
          end
        end else begin
          word_d    = word_q + WordW'(1);
          seq_rd_en = 1'b1;
        end
      end
      StFAddr: begin
        hit_d   = 1'b1;
        res_d   = add_sum[AddrW-1:0];
        state_d = StFin;
      end
      StCSub: begin
        diff_d  = add_sum;
        state_d = StCCmp;
      end
      StCCmp: begin
        if (in_range) begin
          idx_d   = page_off[PageIdxW-1:0];
          state_d = StCRd;
        end else if (last_area) begin
          state_d = StFin;
        end else begin
          area_d  = area_q + AreaIdxW'(1);
          state_d = StCSub;
        end
      end
      StCRd: begin
        seq_rd_en = 1'b1;
        state_d   = StCWr;
      end
      StCWr: begin
        seq_wr_en = 1'b1;
        hit_d     = 1'b1;
        if (last_area) begin
          state_d = StFin;
        end else begin
          area_d  = area_q + AreaIdxW'(1);
          state_d = StCSub;
        end
      end
      StFin: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.hit            = hit_q;
          out_d.result_address = res_q;
          state_d              = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      area_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      area_q      <= area_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    bit_q  <= bit_d;
    idx_q  <= idx_d;
    diff_q <= diff_d;
    req_q  <= req_d;
    hit_q  <= hit_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // No request starts while the bitmap is being swept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> in_stall_o)
    else $error("request accepted during bitmap sweep");

  // The sequencer never writes the bitmap during the sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !seq_wr_en)
    else $error("sequencer write during bitmap sweep");

  // A claim or free changes at most one page bit of the word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_wr_en |-> ($countones(wr_data ^ rd_data) <= 1))
    else $error("bitmap update touches more than one page");

  // The area counter stays within the configured areas.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (area_q <= LastArea))
    else $error("area index out of range");

  // A finished result is loaded and the sequencer returns to idle together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && out_free) |=> (out_valid_q && state_q == StIdle))
    else $error("result not loaded on completion");

endmodule

// File: test/region_bitmap_page_allocator_unit_tb.sv
// Self-checking testbench for the region bitmap page allocator.
`timescale 1ns / 1ps

module region_bitmap_page_allocator_unit_tb;
  import rbpa_pkg::*;

  localparam int AreaCount    = 4;
  localparam int PagesPerArea = 4096;
  localparam int PageShift    = 12;
  localparam int QuietLimit   = 5000;
  localparam int PhaseItems   = 103;
  localparam int RandPhases   = 5;
  localparam logic [FuncW-1:0] FuncUnknown = 2'd3;
  localparam logic [AddrW-1:0] PageBytes   = 48'h1000;

  // Tracks the used bitmap and area layout, and holds the results still due.
  class page_map_scoreboard;
    logic [AddrW-1:0]  base_reg[RegAreas];
    logic [PagesW-1:0] pages_reg[RegAreas];
    bit                used_map[AreaCount][PagesPerArea];
    out_beat_t         due_results[$];
    int mismatches;
    int results_seen;
    int finds;
    int finds_empty;
    int marks;
    int marks_outside;

    function new();
      foreach (base_reg[a]) begin
        base_reg[a]  = '0;
        pages_reg[a] = '0;
      end
    endfunction

    function void set_reg(int idx, logic [CfgDw-1:0] val);
      if (idx < RegFirstPages) begin
        base_reg[idx] = val[AddrW-1:0];
      end else if (idx < 2 * RegAreas) begin
        pages_reg[idx - RegFirstPages] = val[PagesW-1:0];
      end
    endfunction

    // Base of an area with the offset within the page dropped.
    function logic [AddrW-1:0] area_start(int a);
      return base_reg[a] & ~((48'd1 << PageShift) - 48'd1);
    endfunction

    // Pages in use by an area: capped, then rounded down to whole groups.
    function int area_pages(int a);
      int n;
      n = pages_reg[a];
      if (n > PagesPerArea) n = PagesPerArea;
      return n & ~(PageGroup - 1);
    endfunction

    // Applies one request to the bitmap and returns the result it yields.
    function out_beat_t apply_request(in_beat_t req);
      out_beat_t   res;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] addr;
      int          n;
      int          idx;
      res.hit = 1'b0;
      res.result_address = req.page_address;
      case (req.func)
        FuncFind: begin
          finds++;
          res.result_address = '0;
          for (int a = 0; a < AreaCount && !res.hit; a++) begin
            n = area_pages(a);
            for (int i = 0; i < n; i++) begin
              if (!used_map[a][i]) begin
                res.hit = 1'b1;
                res.result_address = area_start(a) + (48'(i) << PageShift);
                break;
              end
            end
          end
          if (!res.hit) finds_empty++;
        end
        FuncClaim, FuncFree: begin
          marks++;
          // The range check is done on wide values so areas at the top do not wrap.
          addr = {16'd0, req.page_address};
          for (int a = 0; a < AreaCount; a++) begin
            n  = area_pages(a);
            lo = {16'd0, area_start(a)};
            hi = lo + (64'(n) << PageShift);
            if (addr >= lo && addr < hi) begin
              idx = int'((addr - lo) >> PageShift);
              used_map[a][idx] = (req.func == FuncClaim);
              res.hit = 1'b1;
            end
          end
          if (!res.hit) marks_outside++;
        end
        default: ;
      endcase
      return res;
    endfunction

    function void take_request(in_beat_t req);
      due_results.push_back(apply_request(req));
    endfunction

    function void match_result(out_beat_t got);
      out_beat_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat: hit %0b address %h",
                 $time, got.hit, got.result_address);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
        mismatches++;
      end
      if (got.result_address !== want.result_address) begin
        $display("%0t: result_address expected %h actual %h",
                 $time, want.result_address, got.result_address);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  in_beat_t         in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_beat_t        out_data_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [CfgAw-1:0] paddr;
  logic [CfgDw-1:0] pwdata;
  logic [CfgDw-1:0] prdata;
  logic             pready;

  page_map_scoreboard sb;
  bit no_idle;
  int items_sent;
  int layouts;

  region_bitmap_page_allocator_unit #(
    .AREA_COUNT    (AreaCount),
    .PAGES_PER_AREA(PagesPerArea),
    .PAGE_SHIFT    (PageShift)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [AddrW-1:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[AddrW-1:0];
  endfunction

  // One register write: setup cycle, then access until pready.
  task automatic reg_write(input int idx, input logic [CfgDw-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAw'(idx * 8);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
  endtask

  // Writes every base and page count, then releases the port.
  task automatic set_layout(input logic [CfgDw-1:0] bases[RegAreas],
                            input logic [CfgDw-1:0] counts[RegAreas]);
    for (int a = 0; a < RegAreas; a++) reg_write(a, bases[a]);
    for (int a = 0; a < RegAreas; a++) reg_write(RegFirstPages + a, counts[a]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    layouts++;
  endtask

  // Offers one request beat, with a random gap ahead of it unless no_idle is set, and waits for it to go in.
  task automatic send_req(input logic [FuncW-1:0] f, input logic [AddrW-1:0] addr);
    in_beat_t beat;
    beat.func = f;
    beat.page_address = addr;
    no_idle = (items_sent >= 250 && items_sent < 330);
    if (!no_idle) begin
      while ($urandom_range(99) < 37) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_request(beat);
    items_sent++;
  endtask

  // Drops valid and waits until every result of the phase is back.
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Result side: checks each beat and stalls at random, once for a long stretch.
  initial begin : result_sink
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.match_result(out_data_o);
      if (!held_once && sb.results_seen == 180) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(99) < 37);
      end
    end
  end

  // Ends the run when no beat or register access moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no beat moved for %0d cycles", $time, QuietLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus: directed layouts first, then random layouts and request mixes.
  initial begin : stimulus
    logic [CfgDw-1:0] bases[RegAreas];
    logic [CfgDw-1:0] counts[RegAreas];
    logic [AddrW-1:0] a0;
    logic [AddrW-1:0] a1;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] b;
    logic [FuncW-1:0] f;
    int               r;
    int               a;
    int               n;
    int               cnt;
    int               sent_here;

    sb = new();
    no_idle = 1'b0;
    items_sent = 0;
    layouts = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset layout: every area disabled, so nothing is found or hit.
    send_req(FuncFind, '0);
    send_req(FuncClaim, '0);
    finish_phase();

    // Two small overlapping areas; area 1 has an unaligned base and a count that
    // rounds down, area 3 a count that rounds to zero.
    a0 = 48'h0000_1000_0000;
    a1 = 48'h0000_1000_4000;
    bases  = '{64'(a0), 64'h0000_0000_1000_4ABC, 64'h0,
               64'hFFFF_FFFF_FFFF_FFFF};
    counts = '{64'd8, 64'd11, 64'd0, 64'hFFFF_0000_0000_0007};
    set_layout(bases, counts);
    send_req(FuncFind, rand48());
    send_req(FuncClaim, a0 + 48'h123);
    send_req(FuncFind, '0);
    send_req(FuncFree, a0);
    send_req(FuncClaim, a0 + 8 * PageBytes - 48'd1);
    send_req(FuncClaim, a0 + 8 * PageBytes);
    send_req(FuncClaim, a1 + 8 * PageBytes);
    send_req(FuncFree, a0 - 48'd1);
    // Fill both areas, then find must come back empty.
    for (int i = 0; i < 12; i++) send_req(FuncClaim, a0 + 48'(i) * PageBytes);
    send_req(FuncFind, '0);
    send_req(FuncFree, a1 + 6 * PageBytes + 48'hFFF);
    send_req(FuncFind, '0);
    send_req(FuncUnknown, 48'hFFFF_FFFF_FFFF);
    finish_phase();

    // Area 0 sits on the top page with an oversized count, so the second page
    // it finds wraps to address zero.
    bases  = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0000_FFFF_FFFF_FFFF,
               64'h0000_8000_0000_0000};
    counts = '{64'd8191, 64'd4096, 64'd1, 64'd15};
    set_layout(bases, counts);
    send_req(FuncFind, '0);
    send_req(FuncClaim, 48'hFFFF_FFFF_FFFF);
    send_req(FuncFind, '0);
    send_req(FuncClaim, '0);
    send_req(FuncFind, '0);
    finish_phase();

    for (int ph = 0; ph < RandPhases; ph++) begin
      // Mostly small areas clustered so that they overlap, a few large or at the top.
      for (int k = 0; k < RegAreas; k++) begin
        r = $urandom_range(99);
        if (r < 15) cnt = 0;
        else if (r < 75) cnt = $urandom_range(8, 24);
        else if (r < 92) cnt = $urandom_range(25, 300);
        else cnt = $urandom_range(4000, 8191);
        r = $urandom_range(99);
        if (r < 60) begin
          b = 48'h0000_4000_0000 + (48'($urandom_range(0, 40)) << PageShift)
              + 48'($urandom_range(0, 4095));
        end else if (r < 85) begin
          b = rand48();
        end else begin
          b = 48'hFFFF_FFFF_FFFF - (48'($urandom_range(0, 40)) << PageShift);
        end
        bases[k]  = {16'($urandom()), b};
        counts[k] = {rand48(), 3'($urandom()), 13'(cnt)};
      end
      set_layout(bases, counts);

      sent_here = 0;
      while (sent_here < PhaseItems) begin
        r = $urandom_range(99);
        if (r < 40) begin
          // Allocation: find a free page, then claim what was found.
          send_req(FuncFind, rand48());
          addr = sb.due_results[$].hit ? sb.due_results[$].result_address : rand48();
          send_req(FuncClaim, addr + 48'($urandom_range(0, 4095)));
          sent_here += 2;
        end else if (r < 95) begin
          if (r < 60) f = FuncFree;
          else if (r < 85) f = FuncClaim;
          else f = FuncFind;
          a = $urandom_range(0, RegAreas - 1);
          n = sb.area_pages(a);
          r = $urandom_range(99);
          if (n > 0 && r < 85) begin
            // A page of the area, or now and then the one just past its end.
            addr = sb.area_start(a) + (48'($urandom_range(0, n)) << PageShift)
                   + 48'($urandom_range(0, 4095));
          end else if (r < 92) begin
            addr = sb.area_start(a) - 48'($urandom_range(1, 4096));
          end else begin
            addr = rand48();
          end
          send_req(f, addr);
          sent_here++;
        end else begin
          // Noise: unknown kind or an address anywhere.
          f = ($urandom_range(1) == 0) ? FuncUnknown : FuncFree;
          send_req(f, rand48());
          sent_here++;
        end
      end
      finish_phase();
    end

    // Any stray result would show up here.
    repeat (300) @(posedge clk_i);
    $display("Ran %0d requests under %0d area layouts: %0d finds (%0d with no free page),",
             items_sent, layouts, sb.finds, sb.finds_empty);
    $display("%0d claims and frees (%0d outside every area), %0d results checked.",
             sb.marks, sb.marks_outside, sb.results_seen);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rbpa_pkg.sv
rtl/core/rbpa_cfg_regs.sv
rtl/core/rbpa_addr_unit.sv
rtl/core/rbpa_bitmap.sv
rtl/core/region_bitmap_page_allocator_unit.sv
test/region_bitmap_page_allocator_unit_tb.sv
